[sv/tcw_pkg.sv]
// Package for the text console writer: operation codes, character constants,
// controller state type and the result record. No dependencies.
package tcw_pkg;

	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam logic [7:0] SPACE_CODE   = 8'h20;
	localparam logic [7:0] COLOR_RESET  = 8'h07;
	localparam logic [7:0] CLEAR_ATTR   = 8'h00;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCROLL,
		ST_FILL,
		ST_RESULT
	} tcw_state_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic [6:0]  cursor_column;
		logic [4:0]  cursor_row;
	} tcw_result_t;

endpackage

[sv/tcw_cmd_if.sv]
// Command channel of the text console writer: valid/ready plus the operation fields.
// Standalone, no package needed.
interface tcw_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [7:0]  char_code;
	logic [10:0] cell_index;

	modport source(output valid, operation, char_code, cell_index, input ready);
	modport sink(input valid, operation, char_code, cell_index, output ready);
endinterface

[sv/tcw_rsp_if.sv]
// Response channel of the text console writer: valid/ready plus the result fields.
// Standalone, no package needed.
interface tcw_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] read_data;
	logic [6:0]  cursor_column;
	logic [4:0]  cursor_row;

	modport source(output valid, read_data, cursor_column, cursor_row, input ready);
	modport sink(input valid, read_data, cursor_column, cursor_row, output ready);
endinterface

[sv/tcw_cfg_if.sv]
// Configuration write channel of the text console writer: valid/ready and the
// attribute byte. Standalone, no package needed.
interface tcw_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_color;

	modport source(output valid, text_color, input ready);
	modport sink(input valid, text_color, output ready);
endinterface

[sv/tcw_screen_ram.sv]
// Screen cell memory: one write port, one read port, registered read data.
// No package dependency.
module tcw_screen_ram #(
	parameter int DEPTH = 2000,
	parameter int AW    = 11
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read strobe
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/tcw_ctrl.sv]
// Console controller: cursor, operation decode, scroll copy and fill sweeps
// over the screen memory. Uses tcw_pkg, tcw_cmd_if; drives tcw_screen_ram.
module tcw_ctrl
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25,
	parameter int AW      = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	tcw_cmd_if.sink       cmd,
	input  logic [7:0]    text_color,
	output logic          res_valid,
	input  logic          res_ready,
	output tcw_result_t   res,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [15:0]   mem_wdata,
	output logic          mem_re,
	output logic [AW-1:0] mem_raddr,
	input  logic [15:0]   mem_rdata
);

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int CW         = $clog2(COLUMNS);
	localparam int RW         = $clog2(ROWS);
	localparam int CNTW       = $clog2(CELL_COUNT + 1);

	tcw_state_t      state_q, state_d;
	logic [CW-1:0]   col_q;
	logic [RW-1:0]   row_q;
	logic [CNTW-1:0] cnt_q;
	logic            prime_q;
	logic            sel_rdata_q;
	logic [15:0]     fill_word_q;

	logic            col_last, row_last, cnt_end, fill_last, read_in_range;
	logic [AW-1:0]   put_addr;
	logic [CNTW-1:0] copy_waddr;
	logic [31:0]     cell_index_ext;
	logic [15:0]     col_ext, row_ext;

	assign col_last       = (col_q == CW'(COLUMNS - 1));
	assign row_last       = (row_q == RW'(ROWS - 1));
	assign cnt_end        = (cnt_q == CNTW'(CELL_COUNT));
	assign fill_last      = (cnt_q == CNTW'(CELL_COUNT - 1));
	assign cell_index_ext = 32'(cmd.cell_index);
	assign read_in_range  = (cell_index_ext < 32'(CELL_COUNT));
	assign put_addr       = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);
	// the word read last cycle came from cnt_q-1, one row below its target
	assign copy_waddr     = cnt_q - CNTW'(COLUMNS + 1);

	assign col_ext = 16'(col_q);
	assign row_ext = 16'(row_q);
	assign res.read_data     = sel_rdata_q ? mem_rdata : 16'h0000;
	assign res.cursor_column = col_ext[6:0];
	assign res.cursor_row    = row_ext[4:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd.ready = (state_q == ST_IDLE);
		res_valid = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.valid) begin
					state_d = ST_RESULT;
					case (cmd.operation)
						OP_PUT: begin
							if (cmd.char_code == NEWLINE_CODE) begin
								if (row_last) begin
									state_d = ST_SCROLL;
								end
							end else begin
								mem_we    = 1'b1;
								mem_waddr = put_addr;
								mem_wdata = {text_color, cmd.char_code};
							end
						end
						OP_CLEAR: begin
							state_d = ST_FILL;
						end
						OP_READ: begin
							mem_re    = read_in_range;
							mem_raddr = cell_index_ext[AW-1:0];
						end
						default: begin
						end
					endcase
				end
			end
			ST_SCROLL: begin
				mem_waddr = copy_waddr[AW-1:0];
				mem_wdata = mem_rdata;
				if (!cnt_end) begin
					mem_re    = 1'b1;
					mem_raddr = cnt_q[AW-1:0];
					mem_we    = prime_q;
				end else begin
					mem_we  = 1'b1;
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q[AW-1:0];
				mem_wdata = fill_word_q;
				if (fill_last) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			cnt_q       <= '0;
			prime_q     <= 1'b0;
			sel_rdata_q <= 1'b0;
			fill_word_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.valid) begin
						sel_rdata_q <= (cmd.operation == OP_READ) && read_in_range;
						case (cmd.operation)
							OP_PUT: begin
								if (cmd.char_code == NEWLINE_CODE) begin
									col_q <= '0;
									if (row_last) begin
										cnt_q       <= CNTW'(COLUMNS);
										prime_q     <= 1'b0;
										fill_word_q <= {text_color, SPACE_CODE};
									end else begin
										row_q <= row_q + RW'(1);
									end
								end else if (col_last) begin
									col_q <= '0;
									row_q <= row_last ? '0 : row_q + RW'(1);
								end else begin
									col_q <= col_q + CW'(1);
								end
							end
							OP_CLEAR: begin
								col_q       <= '0;
								row_q       <= '0;
								cnt_q       <= '0;
								fill_word_q <= {CLEAR_ATTR, SPACE_CODE};
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCROLL: begin
					if (!cnt_end) begin
						cnt_q   <= cnt_q + CNTW'(1);
						prime_q <= 1'b1;
					end else begin
						cnt_q <= CNTW'(CELL_COUNT - COLUMNS);
					end
				end
				ST_FILL: begin
					cnt_q <= cnt_q + CNTW'(1);
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[sv/text_console_writer.sv]
// Top level of the text console writer: attribute register, result register,
// controller and screen memory. Uses tcw_pkg, the channel interfaces,
// tcw_ctrl and tcw_screen_ram.
//
//   channel | interface  | dir | payload
//   --------+------------+-----+-----------------------------------------
//   cmd     | tcw_cmd_if | in  | operation, char_code, cell_index
//   rsp     | tcw_rsp_if | out | read_data, cursor_column, cursor_row
//   cfg     | tcw_cfg_if | in  | text_color (always ready)
//
// Sequencing: a put, read or no-op goes through decode/memory access, then the
// result lands in the output register. Clear sweeps the whole screen, one
// memory write per cycle. A newline on the bottom row scrolls: a read/write
// copy over the single-port-pair memory, then a blank fill of the bottom row.
// Reset: cursor homed, attribute 0x07; screen memory contents undefined.
// Stalls: a new transaction is taken while a result waits in the output
// register; the controller then holds its next result until that one leaves.
module text_console_writer
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic     clk,
	input  logic     arst_n,
	tcw_cmd_if.sink  cmd,
	tcw_rsp_if.source rsp,
	tcw_cfg_if.sink  cfg
);

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int AW         = $clog2(CELL_COUNT);

	logic [7:0]    color_q;
	logic          rsp_valid_q;
	tcw_result_t   rsp_q;

	logic          res_valid, res_ready;
	tcw_result_t   res;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [15:0]   mem_wdata, mem_rdata;

	// attribute byte; the user must write it only while the block is idle, not enforced here
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= COLOR_RESET;
		end else if (cfg.valid) begin
			color_q <= cfg.text_color;
		end
	end

	// output register: frees the controller while the sink stalls
	assign res_ready = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.read_data     = rsp_q.read_data;
	assign rsp.cursor_column = rsp_q.cursor_column;
	assign rsp.cursor_row    = rsp_q.cursor_row;

	tcw_ctrl #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS),
		.AW     (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.text_color(color_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	tcw_screen_ram #(
		.DEPTH(CELL_COUNT),
		.AW   (AW)
	) u_screen_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule

[sv/tcw_checker.sv]
// Port-level checks for the text console writer, bound to the top level.
// Depends on text_console_writer and its channel interfaces.
module tcw_checker #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [15:0] read_data,
	input logic [6:0]  cursor_column,
	input logic [4:0]  cursor_row
);

	logic [1:0] outstanding_q;
	logic       cmd_fire, rsp_fire;

	assign cmd_fire = cmd_valid && cmd_ready;
	assign rsp_fire = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			outstanding_q <= outstanding_q + 2'(cmd_fire) - 2'(rsp_fire);
		end
	end

	// one transaction in the controller at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire |=> !cmd_ready)
		else $error("command accepted while previous one still in work");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_data)
			&& $stable(cursor_column) && $stable(cursor_row))
		else $error("stalled response changed");

	a_no_spurious_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> outstanding_q != 2'd0)
		else $error("response without a command");

	a_outstanding_bound: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q != 2'd3)
		else $error("more than two transactions outstanding");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (32'(cursor_column) < COLUMNS) && (32'(cursor_row) < ROWS))
		else $error("cursor outside the screen");

endmodule

bind text_console_writer tcw_checker #(
	.COLUMNS(COLUMNS),
	.ROWS   (ROWS)
) u_tcw_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cmd_valid    (cmd.valid),
	.cmd_ready    (cmd.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.read_data    (rsp.read_data),
	.cursor_column(rsp.cursor_column),
	.cursor_row   (rsp.cursor_row)
);

[dv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for text_console_writer: random and directed console traffic.
// Needs tcw_pkg, the tcw_cmd_if / tcw_rsp_if / tcw_cfg_if interfaces and the RTL.
module tb_top;
	import tcw_pkg::*;

	// Screen geometry, kept equal to the block's defaults
	localparam int SCREEN_COLS = 80;
	localparam int SCREEN_ROWS = 25;
	localparam int CELLS       = SCREEN_COLS * SCREEN_ROWS;

	// The package leaves the fourth operation code unnamed; the block treats it as a no-op
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int    HOLD_LEN   = 400;         // long receiver hold-off, in cycles
	localparam int    DRAIN_TAIL = 50;          // quiet cycles after the last result
	localparam int    PHASE_LEN  = 90;          // transactions per random phase
	localparam longint TIMEOUT_NS = 80_000_000; // a few times the slowest legal run

	logic clk;
	logic arst_n;

	tcw_cmd_if cmd_if ();
	tcw_rsp_if rsp_if ();
	tcw_cfg_if cfg_if ();

	text_console_writer #(
		.COLUMNS(SCREEN_COLS),
		.ROWS   (SCREEN_ROWS)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_if),
		.rsp   (rsp_if),
		.cfg   (cfg_if)
	);

	// ------------------------------------------------------------------
	// Shadow console: screen words, which cells hold defined data, cursor
	// and the current attribute byte.
	// ------------------------------------------------------------------
	logic [15:0] shadow_screen [CELLS];
	bit          shadow_known  [CELLS];
	int          cur_col;
	int          cur_row;
	logic [7:0]  cur_color;

	// Results still owed by the block, oldest first
	tcw_result_t expected_q [$];

	// Flow control knobs shared by sender and receiver
	bit idle_on     = 1'b1;
	int hold_ticket = 0;

	// Bookkeeping
	int n_sent        = 0;
	int n_checked     = 0;
	int n_mismatch    = 0;
	int n_putc        = 0;
	int n_newline     = 0;
	int n_scroll      = 0;
	int n_bottom_wrap = 0;
	int n_clear       = 0;
	int n_read        = 0;
	int n_read_oor    = 0;
	int n_nop         = 0;
	int n_color       = 0;

	// Clock: 12 ns period
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog
	initial begin
		#(TIMEOUT_NS);
		$display("timeout: %0d results still outstanding", expected_q.size());
		$display("tb_top failed");
		$finish;
	end

	// Mostly back-to-back or short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Advance the shadow console by one transaction and return the result it owes.
	function automatic tcw_result_t console_step(logic [1:0] op, logic [7:0] ch,
			logic [10:0] idx);
		tcw_result_t r;
		int lin;
		r.read_data = '0;
		case (op)
			OP_PUT: begin
				if (ch == NEWLINE_CODE) begin
					// newline writes nothing; below the last row it scrolls, never wraps
					n_newline++;
					cur_col = 0;
					cur_row++;
					if (cur_row >= SCREEN_ROWS) begin
						n_scroll++;
						for (int i = 0; i < CELLS - SCREEN_COLS; i++) begin
							shadow_screen[i] = shadow_screen[i + SCREEN_COLS];
							shadow_known[i]  = shadow_known[i + SCREEN_COLS];
						end
						for (int i = CELLS - SCREEN_COLS; i < CELLS; i++) begin
							shadow_screen[i] = {cur_color, SPACE_CODE};
							shadow_known[i]  = 1'b1;
						end
						cur_row = SCREEN_ROWS - 1;
					end
				end else begin
					n_putc++;
					lin = cur_row * SCREEN_COLS + cur_col;
					shadow_screen[lin] = {cur_color, ch};
					shadow_known[lin]  = 1'b1;
					cur_col++;
					if (cur_col >= SCREEN_COLS) begin
						cur_col = 0;
						cur_row++;
						// running off the bottom by characters goes back to the top
						if (cur_row >= SCREEN_ROWS) begin
							cur_row = 0;
							n_bottom_wrap++;
						end
					end
				end
			end
			OP_CLEAR: begin
				n_clear++;
				for (int i = 0; i < CELLS; i++) begin
					shadow_screen[i] = {CLEAR_ATTR, SPACE_CODE};
					shadow_known[i]  = 1'b1;
				end
				cur_col = 0;
				cur_row = 0;
			end
			OP_READ: begin
				n_read++;
				if (idx < CELLS)
					r.read_data = shadow_screen[idx];
				else
					n_read_oor++;
			end
			default: begin
				n_nop++;
			end
		endcase
		r.cursor_column = cur_col[6:0];
		r.cursor_row    = cur_row[4:0];
		return r;
	endfunction

	// Read target: the cell just behind the cursor, else any defined cell,
	// else somewhere past the end of the screen. Never an unwritten cell.
	function automatic logic [10:0] pick_cell();
		int c;
		if ($urandom_range(0, 2) == 0) begin
			c = cur_row * SCREEN_COLS + cur_col - 1;
			if (c >= 0 && shadow_known[c])
				return c[10:0];
		end
		for (int k = 0; k < 16; k++) begin
			c = $urandom_range(0, 2047);
			if (c >= CELLS || shadow_known[c])
				return c[10:0];
		end
		c = CELLS + $urandom_range(0, 47);
		return c[10:0];
	endfunction

	// One command transaction. valid stays up across back-to-back transactions.
	task automatic send_cmd(logic [1:0] op, logic [7:0] ch, logic [10:0] idx);
		int gap;
		gap = idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			cmd_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_if.valid      <= 1'b1;
		cmd_if.operation  <= op;
		cmd_if.char_code  <= ch;
		cmd_if.cell_index <= idx;
		do
			@(posedge clk);
		while (!cmd_if.ready);
		expected_q.push_back(console_step(op, ch, idx));
		n_sent++;
	endtask

	task automatic send_put(logic [7:0] ch);
		send_cmd(OP_PUT, ch, 11'($urandom_range(0, 2047)));
	endtask

	task automatic send_read(logic [10:0] idx);
		send_cmd(OP_READ, 8'($urandom_range(0, 255)), idx);
	endtask

	// Any printable-or-not byte except newline
	function automatic logic [7:0] pick_text_char();
		logic [7:0] ch;
		ch = 8'($urandom_range(0, 255));
		return (ch == NEWLINE_CODE) ? SPACE_CODE : ch;
	endfunction

	// Stop offering commands and wait until every owed result has come back
	task automatic wait_drain();
		cmd_if.valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Attribute writes happen only with the block idle
	task automatic write_color(logic [7:0] c);
		wait_drain();
		cfg_if.valid      <= 1'b1;
		cfg_if.text_color <= c;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		cur_color = c;
		n_color++;
		cfg_if.valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Receiver: random stalls while idling is on, plus a long hold-off
	// whenever the test bumps hold_ticket.
	// ------------------------------------------------------------------
	initial begin
		int stall;
		int held;
		int seen;
		stall = 0;
		held  = 0;
		seen  = 0;
		rsp_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (seen != hold_ticket) begin
				seen = hold_ticket;
				held = HOLD_LEN;
			end
			if (held > 0) begin
				rsp_if.ready <= 1'b0;
				held--;
			end else if (stall > 0) begin
				rsp_if.ready <= 1'b0;
				stall--;
			end else begin
				rsp_if.ready <= 1'b1;
				if (idle_on && $urandom_range(0, 3) == 0)
					stall = pick_gap();
			end
		end
	end

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			n_mismatch++;
			if (n_mismatch <= 10)
				$display("MISMATCH %s on result %0d: expected 0x%0h, got 0x%0h",
					name, n_checked, want, got);
		end
	endfunction

	// Result checker: every response transaction against the oldest owed result
	always @(posedge clk) begin : check_results
		tcw_result_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (expected_q.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("MISMATCH unexpected result: data 0x%0h col %0d row %0d",
						rsp_if.read_data, rsp_if.cursor_column, rsp_if.cursor_row);
			end else begin
				want = expected_q.pop_front();
				check_field("read_data", want.read_data, rsp_if.read_data);
				check_field("cursor_column", 16'(want.cursor_column), 16'(rsp_if.cursor_column));
				check_field("cursor_row", 16'(want.cursor_row), 16'(rsp_if.cursor_row));
				n_checked++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Field extremes, every operation, out-of-range reads, clear contents,
	// attribute extremes, newline leaving cells alone.
	task automatic test_directed();
		// char byte bit patterns at cells 0..3, then read them back (only written cells)
		send_put(8'h00);
		send_put(8'hFF);
		send_put(8'h55);
		send_put(8'hAA);
		for (int i = 0; i < 4; i++)
			send_read(11'(i));
		// reads past the end of the screen return zero
		send_read(11'd2047);
		send_read(11'(CELLS));
		send_cmd(OP_UNUSED, 8'hFF, 11'd2047);
		send_put(NEWLINE_CODE);
		send_put(8'h41);
		send_read(11'(SCREEN_COLS));
		// clear: whole screen becomes blanks with attribute zero
		send_cmd(OP_CLEAR, 8'h00, 11'd0);
		send_read(11'd0);
		send_read(11'(CELLS - 1));
		send_read(11'd1000);
		// newline must not touch the cell it skips
		send_put(8'h41);
		send_put(NEWLINE_CODE);
		send_read(11'd1);
		// attribute extremes land in the high byte
		write_color(8'hFF);
		send_put(8'h7E);
		send_read(11'(SCREEN_COLS));
		write_color(8'h00);
		send_put(8'h80);
		send_read(11'(SCREEN_COLS + 1));
	endtask

	// Receiver holds off for a long stretch while the sender keeps pushing,
	// so the block fills and stalls its command input; then the sender
	// waits for every result before going on.
	task automatic test_backpressure();
		wait_drain();
		idle_on = 1'b0;
		hold_ticket++;
		for (int i = 0; i < 16; i++)
			send_put(pick_text_char());
		wait_drain();
		idle_on = 1'b1;
	endtask

	// Walk down to the bottom row, scroll several times, then run characters
	// off the end of the bottom row so the cursor goes back to the top.
	task automatic test_scroll_and_wrap();
		int n;
		write_color(8'($urandom_range(1, 254)));
		while (cur_row < SCREEN_ROWS - 1) begin
			n = $urandom_range(0, 3);
			for (int i = 0; i < n; i++)
				send_put(pick_text_char());
			send_put(NEWLINE_CODE);
		end
		for (int s = 0; s < 4; s++) begin
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++)
				send_put(pick_text_char());
			send_put(NEWLINE_CODE);
			// blank row left by the scroll, and the row that moved up
			send_read(11'((SCREEN_ROWS - 1) * SCREEN_COLS + $urandom_range(0, SCREEN_COLS - 1)));
			send_read(11'((SCREEN_ROWS - 2) * SCREEN_COLS + $urandom_range(0, 6)));
		end
		while (cur_row != 0)
			send_put(pick_text_char());
		send_put(pick_text_char());
		send_read(11'd0);
		send_read(11'(CELLS - 1));
	endtask

	task automatic random_item();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (r < 50)
			send_put(8'($urandom_range(0, 255)));
		else if (r < 62)
			send_put(NEWLINE_CODE);
		else if (r < 82)
			send_read(pick_cell());
		else if (r < 85)
			send_cmd(OP_CLEAR, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
		else if (r < 89)
			send_cmd(OP_UNUSED, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
		else begin
			// a run of text, the common case on a real console
			n = $urandom_range(2, 24);
			for (int i = 0; i < n; i++)
				send_put(pick_text_char());
		end
	endtask

	// Random traffic in phases, each under its own attribute byte;
	// one phase runs with no idling at all.
	task automatic test_random_phases();
		logic [7:0] colors [5];
		int start;
		colors[0] = 8'h00;
		colors[1] = 8'hFF;
		colors[2] = 8'($urandom_range(0, 255));
		colors[3] = COLOR_RESET;
		colors[4] = 8'($urandom_range(0, 255));
		for (int p = 0; p < 5; p++) begin
			write_color(colors[p]);
			idle_on = (p != 2);
			start = n_sent;
			while (n_sent - start < PHASE_LEN)
				random_item();
		end
		idle_on = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n            = 1'b0;
		cmd_if.valid      = 1'b0;
		cmd_if.operation  = OP_PUT;
		cmd_if.char_code  = '0;
		cmd_if.cell_index = '0;
		cfg_if.valid      = 1'b0;
		cfg_if.text_color = '0;
		cur_col   = 0;
		cur_row   = 0;
		cur_color = COLOR_RESET;
		for (int i = 0; i < CELLS; i++) begin
			shadow_screen[i] = '0;
			shadow_known[i]  = 1'b0;
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_backpressure();
		test_scroll_and_wrap();
		test_random_phases();

		wait_drain();
		repeat (DRAIN_TAIL) @(posedge clk);

		$display("Covered %0d transactions (%0d checked): %0d chars, %0d newlines, %0d scrolls, %0d bottom wraps",
			n_sent, n_checked, n_putc, n_newline, n_scroll, n_bottom_wrap);
		$display("  %0d clears, %0d reads (%0d off-screen), %0d no-ops, %0d color writes, %0d mismatches",
			n_clear, n_read, n_read_oor, n_nop, n_color, n_mismatch);
		if (n_mismatch == 0 && expected_q.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
